>>> design/rpe_pkg.sv
`default_nettype none
package rpe_pkg;

   localparam int MaxPoints = 256;
   localparam int PsW = $clog2(MaxPoints);
   localparam logic [PsW-1:0] PsMax = PsW'(MaxPoints - 1);

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   localparam logic [2:0] REG_POINT_COUNT = 3'd0;
   localparam logic [2:0] REG_BASE_RADIUS = 3'd1;
   localparam logic [2:0] REG_ANGLE_SINE = 3'd2;
   localparam logic [2:0] REG_ANGLE_COSINE = 3'd3;
   localparam logic [2:0] REG_CLOCKWISE = 3'd4;
   localparam logic [2:0] REG_HEIGHT_STEP = 3'd5;
   localparam logic [2:0] REG_CAP_START = 3'd6;
   localparam logic [2:0] REG_CAP_END = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_DIFF, ST_ABS, ST_SQ, ST_ROOT, ST_DIV, ST_MUL, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      REC_NEAR0, REC_NEAR1, REC_SCAP_VTX, REC_SCAP_TRI, REC_FAR0, REC_FAR1,
      REC_SIDE0, REC_SIDE1, REC_ECAP_VTX, REC_ECAP_TRI
   } rec_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (v < -48'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      if (v > 48'sd32767) begin
         sat16 = 16'sh7fff;
      end else if (v < -48'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

   function automatic logic signed [47:0] rnd14(input logic signed [47:0] p);
      rnd14 = (p + 48'sd8192) >>> 14;
   endfunction

endpackage
`default_nettype wire

>>> design/radial_profile_extrusion_top.sv
`default_nettype none
// Takes a closed profile one point per request and emits vertex and triangle records
// for each profile edge: the edge ending at a point when that point arrives, and the
// closing edge as well when the point carries tlast. Each edge is computed with a 32-step
// bit-serial square root and two 16-step dividers, with one multiplier shared by the
// squares and the rotation products, followed by one record per cycle (six to ten
// records per edge) while the result side is ready. The block takes no request while an
// edge is in work.
module radial_profile_extrusion_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // point_y [31:0], point_z [63:32]
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // slot [11:0], pos_x [43:12], pos_y [75:44], pos_z [107:76], norm_x [123:108],
   // norm_y [139:124], norm_z [155:140], corner_a [166:156], corner_b [177:167],
   // corner_c [188:178], zero fill [191:189]
   output logic [191:0]      rsp_tdata,
   output logic              rsp_tuser,   // record_kind [0]
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   rpe_pkg::state_type state_ff, state_in;

   logic [8:0] point_count_ff;
   logic signed [31:0] base_radius_ff, height_step_ff;
   logic [14:0] angle_sine_ff;
   logic signed [15:0] angle_cosine_ff;
   logic clockwise_ff, cap_start_ff, cap_end_ff;

   logic [rpe_pkg::PsW-1:0] points_seen_ff;
   logic signed [31:0] first_y_ff, first_z_ff, previous_y_ff, previous_z_ff;

   logic signed [31:0] ya_ff, za_ff, yb_ff, zb_ff;
   logic [rpe_pkg::PsW-1:0] idx_ff;
   logic second_ff;

   logic signed [31:0] y1_ff, z1_ff, y2_ff, z2_ff, z1r_ff, z2r_ff;
   logic signed [32:0] dy_ff, dz_ff;
   logic [30:0] a_ff, b_ff;
   logic [4:0] cnt_ff;
   logic signed [65:0] prod_ff;
   logic [63:0] s_ff, r_ff;
   logic [31:0] len_ff;
   logic [46:0] rem_ff;
   logic [14:0] q_ff, ma_ff;
   logic div_sel_ff;
   logic signed [31:0] x1_ff, x2_ff, y1r_ff, y2r_ff;
   logic signed [15:0] nx_ff, ny_ff;
   rpe_pkg::rec_type rec_ff;

   logic rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [191:0] rsp_data_ff;

   logic accept;
   logic signed [32:0] mul_a, mul_b;
   logic signed [15:0] nz_val, n0_val;
   logic [32:0] abs_y, abs_z;
   logic [63:0] root_bit, root_sum;
   logic [46:0] div_sh;
   logic [14:0] q_next;
   logic [3:0] div_k;
   logic signed [47:0] p48;
   logic load;
   logic rec_last;
   rpe_pkg::rec_type rec_next;
   logic [9:0] rec_en;

   logic rk;
   logic [11:0] slot, n12, i12, v12, c1, c2, t1, t2, ca, cb, cc;
   logic signed [31:0] px, py, pz;
   logic signed [15:0] vnx, vny, vnz;

   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;

   assign nz_val = dy_ff[32] ? -$signed({1'b0, ma_ff}) : $signed({1'b0, ma_ff});
   assign n0_val = dz_ff[32] ? $signed({1'b0, q_ff}) : -$signed({1'b0, q_ff});
   assign abs_y = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign abs_z = dz_ff[32] ? 33'(-dz_ff) : 33'(dz_ff);
   assign root_bit = 64'd1 << (6'd62 - {cnt_ff, 1'b0});
   assign root_sum = r_ff + root_bit;
   assign div_k = 4'd15 - cnt_ff[3:0];
   assign div_sh = {15'd0, len_ff} << div_k;
   assign p48 = prod_ff[47:0];

   always_comb begin
      q_next = q_ff;
      if (rem_ff >= div_sh) begin
         q_next[div_k] = 1'b1;
      end
   end

   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      if (state_ff == rpe_pkg::ST_SQ) begin
         mul_a = cnt_ff[0] ? $signed({2'b0, b_ff}) : $signed({2'b0, a_ff});
         mul_b = mul_a;
      end else begin
         unique case (cnt_ff[2:0])
            3'd0: begin
               mul_a = 33'(y1_ff);
               mul_b = $signed({18'd0, angle_sine_ff});
            end
            3'd1: begin
               mul_a = 33'(y2_ff);
               mul_b = $signed({18'd0, angle_sine_ff});
            end
            3'd2: begin
               mul_a = 33'(y1_ff);
               mul_b = 33'(angle_cosine_ff);
            end
            3'd3: begin
               mul_a = 33'(y2_ff);
               mul_b = 33'(angle_cosine_ff);
            end
            3'd4: begin
               mul_a = $signed({18'd0, angle_sine_ff});
               mul_b = 33'(n0_val);
            end
            default: begin
               mul_a = 33'(n0_val);
               mul_b = 33'(angle_cosine_ff);
            end
         endcase
      end
   end

   always_comb begin
      rec_en = 10'b0011110011;
      rec_en[rpe_pkg::REC_SCAP_VTX] = cap_start_ff;
      rec_en[rpe_pkg::REC_SCAP_TRI] = cap_start_ff && (idx_ff > rpe_pkg::PsW'(1));
      rec_en[rpe_pkg::REC_ECAP_VTX] = cap_end_ff;
      rec_en[rpe_pkg::REC_ECAP_TRI] = cap_end_ff && (idx_ff > rpe_pkg::PsW'(1));
      rec_last = 1'b1;
      rec_next = rec_ff;
      for (int k = 9; k >= 0; k--) begin
         if (rec_en[k] && (4'(k) > rec_ff)) begin
            rec_last = 1'b0;
            rec_next = rpe_pkg::rec_type'(4'(k));
         end
      end
   end

   assign load = (state_ff == rpe_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      n12 = {3'd0, point_count_ff};
      i12 = {{(12 - rpe_pkg::PsW){1'b0}}, idx_ff};
      v12 = {i12[9:0], 2'b00};
      c1 = {n12[9:0], 2'b00};
      c2 = c1 + (cap_start_ff ? n12 : 12'd0);
      t1 = (n12 * 12'd6);
      t2 = t1 + (cap_start_ff ? ((n12 - 12'd2) * 12'd3) : 12'd0);
      rk = rpe_pkg::KIND_VERTEX;
      slot = 12'd0;
      px = 32'sd0;
      py = 32'sd0;
      pz = 32'sd0;
      vnx = nx_ff;
      vny = ny_ff;
      vnz = nz_val;
      ca = 12'd0;
      cb = 12'd0;
      cc = 12'd0;
      unique case (rec_ff)
         rpe_pkg::REC_NEAR0: begin
            slot = v12;
            py = y1_ff;
            pz = z1_ff;
         end
         rpe_pkg::REC_NEAR1: begin
            slot = v12 + 12'd1;
            py = y2_ff;
            pz = z2_ff;
         end
         rpe_pkg::REC_SCAP_VTX: begin
            slot = c1 + i12;
            py = y1_ff;
            pz = z1_ff;
            vnx = clockwise_ff ? -16'sd16384 : 16'sd16384;
            vny = 16'sd0;
            vnz = 16'sd0;
         end
         rpe_pkg::REC_FAR0: begin
            slot = v12 + 12'd2;
            px = x1_ff;
            py = y1r_ff;
            pz = z1r_ff;
         end
         rpe_pkg::REC_FAR1: begin
            slot = v12 + 12'd3;
            px = x2_ff;
            py = y2r_ff;
            pz = z2r_ff;
         end
         rpe_pkg::REC_ECAP_VTX: begin
            slot = c2 + i12;
            px = x1_ff;
            py = y1r_ff;
            pz = z1r_ff;
            vnx = rpe_pkg::sat16(clockwise_ff ? 48'(angle_cosine_ff)
                                              : -48'(angle_cosine_ff));
            vny = -$signed({1'b0, angle_sine_ff});
            vnz = 16'sd0;
         end
         rpe_pkg::REC_SCAP_TRI: begin
            rk = rpe_pkg::KIND_TRIANGLE;
            slot = t1 + (i12 - 12'd2) * 12'd3;
            ca = c1;
            cb = clockwise_ff ? c1 + i12 - 12'd1 : c1 + i12;
            cc = clockwise_ff ? c1 + i12 : c1 + i12 - 12'd1;
         end
         rpe_pkg::REC_SIDE0: begin
            rk = rpe_pkg::KIND_TRIANGLE;
            slot = i12 * 12'd6;
            ca = v12;
            cb = clockwise_ff ? v12 + 12'd2 : v12 + 12'd3;
            cc = clockwise_ff ? v12 + 12'd3 : v12 + 12'd2;
         end
         rpe_pkg::REC_SIDE1: begin
            rk = rpe_pkg::KIND_TRIANGLE;
            slot = i12 * 12'd6 + 12'd3;
            ca = v12;
            cb = clockwise_ff ? v12 + 12'd3 : v12 + 12'd1;
            cc = clockwise_ff ? v12 + 12'd1 : v12 + 12'd3;
         end
         rpe_pkg::REC_ECAP_TRI: begin
            rk = rpe_pkg::KIND_TRIANGLE;
            slot = t2 + (i12 - 12'd2) * 12'd3;
            ca = c2;
            cb = clockwise_ff ? c2 + i12 : c2 + i12 - 12'd1;
            cc = clockwise_ff ? c2 + i12 - 12'd1 : c2 + i12;
         end
         default: begin
            rk = rpe_pkg::KIND_VERTEX;
         end
      endcase
      if (rk == rpe_pkg::KIND_TRIANGLE) begin
         vnx = 16'sd0;
         vny = 16'sd0;
         vnz = 16'sd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = (state_ff == rpe_pkg::ST_IDLE);
      unique case (state_ff)
         rpe_pkg::ST_IDLE: begin
            if (accept && ((points_seen_ff != '0) || req_tlast)) begin
               state_in = rpe_pkg::ST_PREP;
            end
         end
         rpe_pkg::ST_PREP: state_in = rpe_pkg::ST_DIFF;
         rpe_pkg::ST_DIFF: state_in = rpe_pkg::ST_ABS;
         rpe_pkg::ST_ABS: state_in = rpe_pkg::ST_SQ;
         rpe_pkg::ST_SQ: begin
            if (cnt_ff == 5'd2) begin
               state_in = rpe_pkg::ST_ROOT;
            end
         end
         rpe_pkg::ST_ROOT: begin
            if (cnt_ff == 5'd31) begin
               state_in = rpe_pkg::ST_DIV;
            end
         end
         rpe_pkg::ST_DIV: begin
            if ((cnt_ff == 5'd15) && div_sel_ff) begin
               state_in = rpe_pkg::ST_MUL;
            end
         end
         rpe_pkg::ST_MUL: begin
            if (cnt_ff == 5'd6) begin
               state_in = rpe_pkg::ST_EMIT;
            end
         end
         rpe_pkg::ST_EMIT: begin
            if (load && rec_last) begin
               state_in = second_ff ? rpe_pkg::ST_PREP : rpe_pkg::ST_IDLE;
            end
         end
         default: state_in = rpe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 9'd3;
         base_radius_ff <= 32'sd0;
         angle_sine_ff <= 15'd0;
         angle_cosine_ff <= 16'sd16384;
         clockwise_ff <= 1'b1;
         height_step_ff <= 32'sd0;
         cap_start_ff <= 1'b0;
         cap_end_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rpe_pkg::REG_POINT_COUNT: point_count_ff <= csr_data[8:0];
            rpe_pkg::REG_BASE_RADIUS: base_radius_ff <= csr_data;
            rpe_pkg::REG_ANGLE_SINE: angle_sine_ff <= csr_data[14:0];
            rpe_pkg::REG_ANGLE_COSINE: angle_cosine_ff <= csr_data[15:0];
            rpe_pkg::REG_CLOCKWISE: clockwise_ff <= csr_data[0];
            rpe_pkg::REG_HEIGHT_STEP: height_step_ff <= csr_data;
            rpe_pkg::REG_CAP_START: cap_start_ff <= csr_data[0];
            rpe_pkg::REG_CAP_END: cap_end_ff <= csr_data[0];
            default: point_count_ff <= point_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_seen_ff <= '0;
         first_y_ff <= 32'sd0;
         first_z_ff <= 32'sd0;
         previous_y_ff <= 32'sd0;
         previous_z_ff <= 32'sd0;
      end else if (accept) begin
         if (points_seen_ff == '0) begin
            first_y_ff <= req_tdata[31:0];
            first_z_ff <= req_tdata[63:32];
         end
         if (req_tlast) begin
            points_seen_ff <= '0;
         end else begin
            previous_y_ff <= req_tdata[31:0];
            previous_z_ff <= req_tdata[63:32];
            if (points_seen_ff < rpe_pkg::PsMax) begin
               points_seen_ff <= points_seen_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 5'd0;
         second_ff <= 1'b0;
         div_sel_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            rpe_pkg::ST_IDLE: begin
               cnt_ff <= 5'd0;
               if (accept) begin
                  if (points_seen_ff != '0) begin
                     ya_ff <= previous_y_ff;
                     za_ff <= previous_z_ff;
                     idx_ff <= points_seen_ff - 1'b1;
                     second_ff <= req_tlast;
                  end else begin
                     ya_ff <= req_tdata[31:0];
                     za_ff <= req_tdata[63:32];
                     idx_ff <= '0;
                     second_ff <= 1'b0;
                  end
                  yb_ff <= req_tdata[31:0];
                  zb_ff <= req_tdata[63:32];
               end
            end
            rpe_pkg::ST_PREP: begin
               y1_ff <= rpe_pkg::sat32(48'(ya_ff) + 48'(base_radius_ff));
               y2_ff <= rpe_pkg::sat32(48'(yb_ff) + 48'(base_radius_ff));
               z1_ff <= za_ff;
               z2_ff <= zb_ff;
               z1r_ff <= rpe_pkg::sat32(48'(za_ff) + 48'(height_step_ff));
               z2r_ff <= rpe_pkg::sat32(48'(zb_ff) + 48'(height_step_ff));
            end
            rpe_pkg::ST_DIFF: begin
               dy_ff <= 33'(y2_ff) - 33'(y1_ff);
               dz_ff <= 33'(z2_ff) - 33'(z1_ff);
            end
            rpe_pkg::ST_ABS: begin
               if (abs_y[31] || abs_z[31]) begin
                  a_ff <= abs_y[31:1];
                  b_ff <= abs_z[31:1];
               end else begin
                  a_ff <= abs_y[30:0];
                  b_ff <= abs_z[30:0];
               end
            end
            rpe_pkg::ST_SQ: begin
               prod_ff <= mul_a * mul_b;
               if (cnt_ff == 5'd1) begin
                  s_ff <= prod_ff[63:0];
               end
               if (cnt_ff == 5'd2) begin
                  s_ff <= s_ff + prod_ff[63:0];
                  r_ff <= 64'd0;
                  cnt_ff <= 5'd0;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            rpe_pkg::ST_ROOT: begin
               if (s_ff >= root_sum) begin
                  s_ff <= s_ff - root_sum;
                  r_ff <= (r_ff >> 1) + root_bit;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               if (cnt_ff == 5'd31) begin
                  len_ff <= (s_ff >= root_sum) ? 32'((r_ff >> 1) + root_bit) : 32'(r_ff >> 1);
                  div_sel_ff <= 1'b0;
               end
               cnt_ff <= cnt_ff + 5'd1;
            end
            rpe_pkg::ST_DIV: begin
               if (cnt_ff == 5'd0) begin
                  rem_ff <= {2'b00, (div_sel_ff ? b_ff : a_ff), 14'd0} + {16'd0, len_ff[31:1]};
                  q_ff <= 15'd0;
                  cnt_ff <= 5'd1;
               end else begin
                  if (rem_ff >= div_sh) begin
                     rem_ff <= rem_ff - div_sh;
                  end
                  q_ff <= q_next;
                  if (cnt_ff == 5'd15) begin
                     cnt_ff <= 5'd0;
                     div_sel_ff <= 1'b1;
                     if (len_ff == 32'd0) begin
                        q_ff <= 15'd0;
                     end
                     if (!div_sel_ff) begin
                        ma_ff <= (len_ff == 32'd0) ? 15'd0 : q_next;
                     end
                  end else begin
                     cnt_ff <= cnt_ff + 5'd1;
                  end
               end
            end
            rpe_pkg::ST_MUL: begin
               prod_ff <= mul_a * mul_b;
               unique case (cnt_ff[2:0])
                  3'd1: x1_ff <= rpe_pkg::sat32(clockwise_ff ? rpe_pkg::rnd14(p48)
                                                             : -rpe_pkg::rnd14(p48));
                  3'd2: x2_ff <= rpe_pkg::sat32(clockwise_ff ? rpe_pkg::rnd14(p48)
                                                             : -rpe_pkg::rnd14(p48));
                  3'd3: y1r_ff <= rpe_pkg::sat32(rpe_pkg::rnd14(p48));
                  3'd4: y2r_ff <= rpe_pkg::sat32(rpe_pkg::rnd14(p48));
                  3'd5: nx_ff <= rpe_pkg::sat16(rpe_pkg::rnd14(-p48));
                  3'd6: ny_ff <= rpe_pkg::sat16(rpe_pkg::rnd14(p48));
                  default: nx_ff <= nx_ff;
               endcase
               if (cnt_ff == 5'd6) begin
                  cnt_ff <= 5'd0;
                  rec_ff <= rpe_pkg::REC_NEAR0;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            rpe_pkg::ST_EMIT: begin
               if (load) begin
                  rec_ff <= rec_next;
                  if (rec_last && second_ff) begin
                     ya_ff <= yb_ff;
                     za_ff <= zb_ff;
                     yb_ff <= first_y_ff;
                     zb_ff <= first_z_ff;
                     idx_ff <= idx_ff + 1'b1;
                     second_ff <= 1'b0;
                  end
               end
            end
            default: cnt_ff <= 5'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff <= rk;
         rsp_last_ff <= rec_last && !second_ff;
         rsp_data_ff <= {3'd0, cc[10:0], cb[10:0], ca[10:0], vnz, vny, vnx, pz, py, px, slot};
      end
   end

endmodule
`default_nettype wire
